// ===== rtl/core/configurable_crc_msb_first_assert.svh =====
// Assertion macros for the configurable MSB-first CRC engine.
`ifndef CONFIGURABLE_CRC_MSB_FIRST_ASSERT_SVH
`define CONFIGURABLE_CRC_MSB_FIRST_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define CCRC_ASSERT_NOW(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define CCRC_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define CCRC_ASSERT_NOW(name, clk, rst_n, cond, prop)
`define CCRC_ASSERT_NEXT(name, clk, rst_n, cond, prop)

`endif

`endif

// ===== rtl/core/ccrc_pkg.sv =====
// Shared types and constants for the configurable CRC engine.
package ccrc_pkg;

    localparam int CRC_W   = 32;
    localparam int DATA_W  = 8;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 2;

    // Width mode codes
    localparam logic [MODE_W-1:0] MODE_CRC8  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CRC16 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CRC32 = 2'd2;

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_WIDTH_MODE    = 2'd0;
    localparam logic [INDEX_W-1:0] REG_POLYNOMIAL    = 2'd1;
    localparam logic [INDEX_W-1:0] REG_INITIAL_VALUE = 2'd2;

    // Reset values
    localparam logic [MODE_W-1:0] RST_WIDTH_MODE    = MODE_CRC32;
    localparam logic [CRC_W-1:0]  RST_POLYNOMIAL    = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0]  RST_INITIAL_VALUE = 32'hFFFF_FFFF;

    localparam logic [CRC_W-1:0] TOP_BIT_32 = 32'h8000_0000;
    localparam logic [CRC_W-1:0] TOP_BIT_16 = 32'h0000_8000;
    localparam logic [CRC_W-1:0] TOP_BIT_8  = 32'h0000_0080;

    typedef struct packed {
        logic [MODE_W-1:0] width_mode;
        logic [CRC_W-1:0]  polynomial;
        logic [CRC_W-1:0]  initial_value;
    } ccrc_cfg_t;

endpackage

// ===== rtl/core/ccrc_if.sv =====
// Item channels of the CRC engine: input byte channel and result channel.
interface ccrc_in_if
    import ccrc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface ccrc_out_if
    import ccrc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CRC_W-1:0] crc_value;
    logic             is_last;

    modport source (output valid, crc_value, is_last, input ready);
    modport sink   (input valid, crc_value, is_last, output ready);
endinterface

// ===== rtl/core/ccrc_byte_step.sv =====
// One-byte CRC update: seed select, byte merge and eight unrolled shift steps.
module ccrc_byte_step
    import ccrc_pkg::*;
(
    input  ccrc_cfg_t         cfg,
    input  logic [CRC_W-1:0]  running_crc,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              first_byte,
    output logic [CRC_W-1:0]  crc_out
);

    logic [CRC_W-1:0] mask;
    logic [CRC_W-1:0] top;
    logic [CRC_W-1:0] merged;
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] crc;

    always_comb
    begin
        case (cfg.width_mode)
            MODE_CRC8:
            begin
                mask   = 32'h0000_00FF;
                top    = TOP_BIT_8;
                merged = {24'd0, data_byte};
            end
            MODE_CRC16:
            begin
                mask   = 32'h0000_FFFF;
                top    = TOP_BIT_16;
                merged = {16'd0, data_byte, 8'd0};
            end
            default:
            begin
                mask   = 32'hFFFF_FFFF;
                top    = TOP_BIT_32;
                merged = {data_byte, 24'd0};
            end
        endcase
    end

    always_comb
    begin
        poly = cfg.polynomial & mask;
        crc  = (first_byte ? cfg.initial_value : running_crc) & mask;
        crc  = (crc ^ merged) & mask;
        for (int k = 0; k < DATA_W; k++)
        begin
            // shift out the top bit, fold in the polynomial when it was set
            if ((crc & top) != '0)
                crc = ((crc << 1) ^ poly) & mask;
            else
                crc = (crc << 1) & mask;
        end
        crc_out = crc;
    end

endmodule

// ===== rtl/core/configurable_crc_msb_first.sv =====
// Configurable MSB-first CRC engine (8, 16 or 32 bits, non-reflected, no final XOR).
// Takes one message byte per cycle, unless stalled, on the data channel and returns one
// result per byte on the result channel: the running CRC after that byte, zero-extended
// to 32 bits, and an echo of the last-byte flag. A byte is captured in an input
// register, the eight shift steps run in combinational logic, and the CRC lands in the
// result register, where it is held until the result side takes it; bytes stream at
// one per cycle while the result side keeps up. The width, polynomial and initial
// value registers are written through the wr_* port; the user must write them only
// while no item is in flight, and the block does not enforce this. Width code three
// acts as 32 bits. A first_byte flag reloads the initial value; without it the CRC
// continues from the last result (zero after reset).
module configurable_crc_msb_first
    import ccrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [INDEX_W-1:0] wr_index,
    input  logic [CRC_W-1:0]   wr_data,
    ccrc_in_if.sink            data,
    ccrc_out_if.source         result
);

`include "configurable_crc_msb_first_assert.svh"

    ccrc_cfg_t         cfg_reg;
    logic [CRC_W-1:0]  running_crc_reg;

    logic              s1_valid_reg;
    logic [DATA_W-1:0] s1_byte_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;

    logic              out_valid_reg;
    logic [CRC_W-1:0]  out_crc_reg;
    logic              out_last_reg;

    logic              s1_ready;
    logic              s1_adv;
    logic [CRC_W-1:0]  crc_next;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign s1_ready = !s1_valid_reg || s1_adv;

    assign data.ready       = s1_ready;
    assign result.valid     = out_valid_reg;
    assign result.crc_value = out_crc_reg;
    assign result.is_last   = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_mode    <= RST_WIDTH_MODE;
            cfg_reg.polynomial    <= RST_POLYNOMIAL;
            cfg_reg.initial_value <= RST_INITIAL_VALUE;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_WIDTH_MODE:    cfg_reg.width_mode    <= wr_data[MODE_W-1:0];
                REG_POLYNOMIAL:    cfg_reg.polynomial    <= wr_data;
                REG_INITIAL_VALUE: cfg_reg.initial_value <= wr_data;
                default:           ;
            endcase
        end
    end

    ccrc_byte_step u_step (
        .cfg         (cfg_reg),
        .running_crc (running_crc_reg),
        .data_byte   (s1_byte_reg),
        .first_byte  (s1_first_reg),
        .crc_out     (crc_next)
    );

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            running_crc_reg <= '0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= data.valid;
            if (s1_adv)
            begin
                out_valid_reg   <= 1'b1;
                running_crc_reg <= crc_next;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && data.valid)
        begin
            s1_byte_reg  <= data.data_byte;
            s1_first_reg <= data.first_byte;
            s1_last_reg  <= data.last_byte;
        end
        if (s1_adv)
        begin
            out_crc_reg  <= crc_next;
            out_last_reg <= s1_last_reg;
        end
    end

    `CCRC_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, s1_adv, out_valid_reg)
    `CCRC_ASSERT_NEXT(a_state_tracks_out, clk, rst_n, s1_adv, running_crc_reg == out_crc_reg)
    `CCRC_ASSERT_NOW(a_stall_only_full, clk, rst_n, !s1_ready, s1_valid_reg && out_valid_reg && !result.ready)

endmodule
